/* hdl/lik_pkg.sv */
// Shared constants, widths and the arctangent table for the leg inverse kinematics pipeline.
// No dependencies; used by lik_cordic, lik_isqrt and leg_inverse_kinematics_3dof.
`default_nettype none
package lik_pkg;

  // Arithmetic configuration
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 6;

  // Datapath widths
  localparam int CW         = 36;               // CORDIC x/y width, signed
  localparam int ZW         = 26;               // angle accumulator width, Q16 degrees
  localparam int SQRT_STEPS = 31;               // root bits
  localparam int SQ_IN_W    = 2 * SQRT_STEPS;   // radicand width
  localparam int DIV_STEPS  = 30;               // Q30 cosine quotient bits
  localparam int LEN_W      = 14;
  localparam int COORD_W    = 16;
  localparam int ANG_OUT_W  = 14;

  // Pipeline latencies
  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int SQRT_LAT   = SQRT_STEPS;
  localparam int DIV_LAT    = DIV_STEPS + 1;

  // Angles in Q16 degrees
  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

  // Register indexes and reset values
  localparam logic [1:0] REG_COXA  = 2'd0;
  localparam logic [1:0] REG_FEMUR = 2'd1;
  localparam logic [1:0] REG_TIBIA = 2'd2;
  localparam logic [LEN_W-1:0] COXA_RST  = LEN_W'(480);
  localparam logic [LEN_W-1:0] FEMUR_RST = LEN_W'(960);
  localparam logic [LEN_W-1:0] TIBIA_RST = LEN_W'(1280);

  // atan(2^-i) in Q16 degrees, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = ZW'(2949120);
      1:  a = ZW'(1740967);
      2:  a = ZW'(919879);
      3:  a = ZW'(466945);
      4:  a = ZW'(234379);
      5:  a = ZW'(117306);
      6:  a = ZW'(58666);
      7:  a = ZW'(29335);
      8:  a = ZW'(14668);
      9:  a = ZW'(7334);
      10: a = ZW'(3667);
      11: a = ZW'(1833);
      12: a = ZW'(917);
      13: a = ZW'(458);
      14: a = ZW'(229);
      15: a = ZW'(115);
      16: a = ZW'(57);
      17: a = ZW'(29);
      18: a = ZW'(14);
      19: a = ZW'(7);
      20: a = ZW'(4);
      21: a = ZW'(2);
      22: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* hdl/lik_cordic.sv */
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q16 degrees.
// Depends on lik_pkg for widths, step count and the arctangent table.
`default_nettype none
module lik_cordic (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [lik_pkg::CW-1:0] x_i,
  input  logic signed [lik_pkg::CW-1:0] y_i,
  output logic signed [lik_pkg::ZW-1:0] z_o
);
  localparam int N = lik_pkg::CORDIC_STEPS;

  logic signed [lik_pkg::CW-1:0] x_q [N+1];
  logic signed [lik_pkg::CW-1:0] y_q [N+1];
  logic signed [lik_pkg::ZW-1:0] z_q [N+1];
  logic                          zero_q [N+1];

  logic signed [lik_pkg::CW-1:0] x0, y0;
  logic signed [lik_pkg::ZW-1:0] z0;

  // Turn a left-half-plane vector by 90 degrees
  always_comb begin
    x0 = x_i;
    y0 = y_i;
    z0 = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0 = y_i;
        y0 = -x_i;
        z0 = lik_pkg::DEG90;
      end else begin
        x0 = -y_i;
        y0 = x_i;
        z0 = -lik_pkg::DEG90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + lik_pkg::atan_entry(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - lik_pkg::atan_entry(i);
        end
      end
    end
  end

  // Zero vector gives angle zero
  assign z_o = zero_q[N] ? '0 : z_q[N];

endmodule
`default_nettype wire

/* hdl/lik_isqrt.sv */
// Pipelined floor integer square root, one root bit per stage.
// Depends on lik_pkg for widths.
`default_nettype none
module lik_isqrt (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [lik_pkg::SQ_IN_W-1:0]      v_i,
  output logic [lik_pkg::SQRT_STEPS-1:0]   root_o
);
  localparam int W = lik_pkg::SQ_IN_W;
  localparam int N = lik_pkg::SQRT_STEPS;

  logic [W-1:0] v_q [N];
  logic [W-1:0] r_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic [W-1:0] STEP_BIT = W'(1) << (W - 2 - 2 * i);
    logic [W-1:0] v_in, r_in, trial;

    if (i == 0) begin : g_first
      assign v_in = v_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign r_in = r_q[i-1];
    end

    assign trial = r_in + STEP_BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          v_q[i] <= v_in - trial;
          r_q[i] <= (r_in >> 1) + STEP_BIT;
        end else begin
          v_q[i] <= v_in;
          r_q[i] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[N-1][N-1:0];

endmodule
`default_nettype wire

/* hdl/leg_inverse_kinematics_3dof.sv */
// Top level of the three-link leg inverse kinematics pipeline (coxa, femur, tibia servo angles).
// Depends on lik_pkg, lik_cordic and lik_isqrt.
//
// The block turns one foot position (forward, up, lateral; signed 1/16 mm) into three servo
// angles in 1/64 degree, saturated to 0..180 degrees. It takes one item per clock while
// s_axis_tready is high and keeps no state between items. An accepted item passes through
// the reach root -> leg-plane root -> Q30 cosine divider -> sine root -> CORDIC chain, with
// register stages between them, all fully pipelined. A stalled output is absorbed by a
// one-item skid register; only when both the output register and the skid hold items does
// the pipeline freeze and s_axis_tready drop. Link lengths are to be written through the cfg
// port only while no item is in flight; the block itself does not enforce this. The derived
// length products are registered from the link length registers.
`default_nettype none
module leg_inverse_kinematics_3dof (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,   // REG_COXA, REG_FEMUR, REG_TIBIA
  input  logic [13:0] cfg_data_i,
  // foot position in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [15:0] foot_forward, [31:16] foot_up, [47:32] foot_lateral
  // servo angles out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [13:0] coxa_angle, [27:14] femur_angle,
                                     // [41:28] tibia_angle, [47:42] zero
);
  localparam int CW    = lik_pkg::CW;
  localparam int ZW    = lik_pkg::ZW;
  localparam int AW    = ZW + 2;
  localparam int LW    = lik_pkg::LEN_W;
  localparam int OW    = lik_pkg::ANG_OUT_W;
  localparam int SQ_W  = lik_pkg::SQ_IN_W;
  localparam int RT_W  = lik_pkg::SQRT_STEPS;
  localparam int NUM_W = 48;
  localparam int DEN_W = 47;
  localparam int DS    = lik_pkg::DIV_STEPS;

  // Stage timeline, counted in registers after acceptance
  localparam int T_RR    = 1 + lik_pkg::SQRT_LAT;
  localparam int T_XP    = T_RR + 1;
  localparam int T_XSQ   = T_XP + 1;
  localparam int T_LD    = T_XSQ + lik_pkg::SQRT_LAT;
  localparam int T_LDC   = T_LD + 1;
  localparam int T_LDSQ  = T_LDC + 1;
  localparam int T_C     = T_LDSQ + lik_pkg::DIV_LAT;
  localparam int T_CSQ   = T_C + 1;
  localparam int T_S     = T_CSQ + lik_pkg::SQRT_LAT;
  localparam int T_ANG   = T_S + lik_pkg::CORDIC_LAT;
  localparam int D_COXA  = T_ANG - lik_pkg::CORDIC_LAT;
  localparam int D_ALPHA = T_ANG - T_XP - lik_pkg::CORDIC_LAT;

  localparam int SHR = 16 - lik_pkg::ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] RND = AW'(1) << (15 - lik_pkg::ANGLE_FRAC_BITS);

  // ceil(2^35 / 50): exact floor division by 50 for values below 2^29
  localparam logic [29:0] RECIP50 = 30'd687194768;
  localparam logic signed [31:0] Q30_ONE = 32'sd1 <<< 30;
  localparam logic [SQ_W-1:0] Q60_ONE = SQ_W'(1) << 60;

  function automatic logic [OW-1:0] to_out(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] c;
    logic [AW-1:0] r;
    c = v;
    if (v < 0) c = '0;
    else if (v > AW'(lik_pkg::DEG180)) c = AW'(lik_pkg::DEG180);
    r = (AW'(c) + RND) >> SHR;
    return r[OW-1:0];
  endfunction

  // ---------------- configuration ----------------
  logic [LW-1:0] lc_q, lf_q, lt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= lik_pkg::COXA_RST;
      lf_q <= lik_pkg::FEMUR_RST;
      lt_q <= lik_pkg::TIBIA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lik_pkg::REG_COXA:  lc_q <= cfg_data_i;
        lik_pkg::REG_FEMUR: lf_q <= cfg_data_i;
        lik_pkg::REG_TIBIA: lt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Products of the link lengths, recomputed every cycle
  logic [27:0] lf2_q, lt2_q, lflt_q;
  logic [28:0] sumlen_q;
  logic [22:0] maxr_q, minr_q;
  logic [LW:0] ldiff;
  logic [58:0] maxr_prod;

  assign ldiff     = (lf_q >= lt_q) ? (LW+1)'(lf_q - lt_q) : (LW+1)'(lt_q - lf_q);
  assign maxr_prod = 59'(sumlen_q) * 59'(RECIP50);

  always_ff @(posedge clk_i) begin
    lf2_q    <= 28'(lf_q * lf_q);
    lt2_q    <= 28'(lt_q * lt_q);
    lflt_q   <= 28'(lf_q * lt_q);
    sumlen_q <= 29'(((LW+1)'(lf_q) + (LW+1)'(lt_q)) * 29'd12544);
    maxr_q   <= maxr_prod[57:35];
    minr_q   <= {ldiff + (LW+1)'(32), 8'h00};
  end

  // ---------------- flow control ----------------
  logic en;
  logic skid_valid_q, out_valid_q;
  logic [T_ANG:0] vld_q;

  // Freeze the whole pipeline only when the skid holds an item
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[T_ANG-1:0], s_axis_tvalid};
    end
  end

  // ---------------- stage 0: capture, outward distance ----------------
  logic signed [15:0] fwd_q, up_q;
  logic [16:0]        outw_q;
  logic signed [16:0] lat_ext;

  assign lat_ext = {s_axis_tdata[47], s_axis_tdata[47:32]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_q  <= s_axis_tdata[15:0];
      up_q   <= s_axis_tdata[31:16];
      outw_q <= lat_ext[16] ? 17'(-lat_ext) : 17'(lat_ext);
    end
  end

  // Coxa angle: atan2(forward, outward)
  logic signed [ZW-1:0] coxa_z;

  lik_cordic u_coxa (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ($signed({{(CW-33){1'b0}}, outw_q, 16'h0000})),
    .y_i   ($signed({{(CW-32){fwd_q[15]}}, fwd_q, 16'h0000})),
    .z_o   (coxa_z)
  );

  // ---------------- horizontal reach ----------------
  logic [33:0] osq_q;
  logic [31:0] fsq_q;
  logic [RT_W-1:0] rr_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      osq_q <= 34'(outw_q * outw_q);
      fsq_q <= 32'(fwd_q * fwd_q);
    end
  end

  lik_isqrt u_reach (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (SQ_W'({35'(osq_q) + 35'(fsq_q), 16'h0000})),
    .root_o (rr_w)
  );

  logic signed [15:0] up_dly_q [T_RR];

  always_ff @(posedge clk_i) begin
    if (en) begin
      up_dly_q[0] <= up_q;
      for (int i = 1; i < T_RR; i++) up_dly_q[i] <= up_dly_q[i-1];
    end
  end

  // ---------------- leg plane ----------------
  logic signed [25:0] xp_q, zp_q;
  logic [51:0]        xsq_q, zsq_q;
  logic signed [15:0] up_rr;

  assign up_rr = up_dly_q[T_RR-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      xp_q  <= $signed({2'b00, rr_w[23:0]}) - $signed({4'b0000, lc_q, 8'h00});
      zp_q  <= -$signed({{2{up_rr[15]}}, up_rr, 8'h00});
      xsq_q <= 52'(xp_q * xp_q);
      zsq_q <= 52'(zp_q * zp_q);
    end
  end

  // Alpha: atan2(down, plane reach)
  logic signed [ZW-1:0] alpha_z;

  lik_cordic u_alpha (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ($signed({{(CW-34){xp_q[25]}}, xp_q, 8'h00})),
    .y_i   ($signed({{(CW-34){zp_q[25]}}, zp_q, 8'h00})),
    .z_o   (alpha_z)
  );

  logic [RT_W-1:0] ld_w;

  lik_isqrt u_plane (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (SQ_W'(53'(xsq_q) + 53'(zsq_q))),
    .root_o (ld_w)
  );

  // Saturate the reach; the lower bound wins when the bounds cross
  logic [22:0] ld_q;
  logic [22:0] ld_c;

  always_comb begin
    ld_c = ld_w[22:0];
    if (ld_w[24:0] > 25'(maxr_q)) ld_c = maxr_q;
    if (ld_c < minr_q) ld_c = minr_q;
  end

  logic [45:0] ldsq_q;
  logic [36:0] lfld_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ld_q   <= ld_c;
      ldsq_q <= 46'(ld_q * ld_q);
      lfld_q <= 37'(lf_q * ld_q);
    end
  end

  // ---------------- law of cosines: knee (lane 0), beta (lane 1) ----------------
  logic signed [NUM_W-1:0] acos_num [2];
  logic [DEN_W-1:0]        acos_den [2];
  logic signed [ZW-1:0]    acos_ang [2];
  logic [28:0]             l2sum;

  assign l2sum       = 29'(lf2_q) + 29'(lt2_q);
  assign acos_num[0] = $signed({3'b000, l2sum, 16'h0000}) - $signed({2'b00, ldsq_q});
  assign acos_den[0] = {2'b00, lflt_q, 17'h00000};
  assign acos_num[1] = $signed({4'h0, lf2_q, 16'h0000}) + $signed({2'b00, ldsq_q})
                     - $signed({4'h0, lt2_q, 16'h0000});
  assign acos_den[1] = {1'b0, lfld_q, 9'h000};

  for (genvar l = 0; l < 2; l++) begin : g_acos
    logic [3:0]              k;
    logic signed [NUM_W-1:0] num_s;
    logic [DEN_W-1:0]        den_s;
    logic signed [NUM_W-1:0] mag_s;

    // Halve numerator and denominator until the denominator fits 32 bits
    always_comb begin
      k = '0;
      for (int j = 32; j < DEN_W; j++) begin
        if (acos_den[l][j]) k = 4'(j - 31);
      end
      num_s = acos_num[l] >>> k;
      den_s = acos_den[l] >> k;
      mag_s = num_s[NUM_W-1] ? -num_s : num_s;
    end

    logic [32:0]   dr_q [DS+1];
    logic [DS-1:0] dq_q [DS+1];
    logic [31:0]   dd_q [DS+1];
    logic          neg_q [DS+1];
    logic          sat_q [DS+1];
    logic          satn_q [DS+1];

    always_ff @(posedge clk_i) begin
      if (en) begin
        dr_q[0]   <= {1'b0, mag_s[31:0]};
        dq_q[0]   <= '0;
        dd_q[0]   <= den_s[31:0];
        neg_q[0]  <= num_s[NUM_W-1];
        sat_q[0]  <= (num_s >= $signed({1'b0, den_s})) || (num_s <= -$signed({1'b0, den_s}));
        satn_q[0] <= num_s < $signed({1'b0, den_s});
      end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar j = 0; j < DS; j++) begin : g_div
      logic [32:0] r2;
      assign r2 = {dr_q[j][31:0], 1'b0};
      always_ff @(posedge clk_i) begin
        if (en) begin
          dd_q[j+1]   <= dd_q[j];
          neg_q[j+1]  <= neg_q[j];
          sat_q[j+1]  <= sat_q[j];
          satn_q[j+1] <= satn_q[j];
          if (r2 >= {1'b0, dd_q[j]}) begin
            dr_q[j+1] <= r2 - {1'b0, dd_q[j]};
            dq_q[j+1] <= {dq_q[j][DS-2:0], 1'b1};
          end else begin
            dr_q[j+1] <= r2;
            dq_q[j+1] <= {dq_q[j][DS-2:0], 1'b0};
          end
        end
      end
    end

    logic signed [31:0] cos_c;
    logic [30:0]        cos_mag;

    always_comb begin
      if (sat_q[DS]) cos_c = satn_q[DS] ? -Q30_ONE : Q30_ONE;
      else           cos_c = neg_q[DS] ? -$signed(32'(dq_q[DS])) : $signed(32'(dq_q[DS]));
      cos_mag = cos_c[31] ? 31'(-cos_c) : 31'(cos_c);
    end

    logic [60:0]        csq_q;
    logic signed [31:0] c_dly_q [lik_pkg::SQRT_LAT+1];
    logic [RT_W-1:0]    sin_w;

    always_ff @(posedge clk_i) begin
      if (en) begin
        csq_q      <= 61'(cos_mag * cos_mag);
        c_dly_q[0] <= cos_c;
        for (int i = 1; i <= lik_pkg::SQRT_LAT; i++) c_dly_q[i] <= c_dly_q[i-1];
      end
    end

    lik_isqrt u_sin (
      .clk_i  (clk_i),
      .en_i   (en),
      .v_i    (Q60_ONE - SQ_W'(csq_q)),
      .root_o (sin_w)
    );

    lik_cordic u_acos (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (CW'(c_dly_q[lik_pkg::SQRT_LAT])),
      .y_i   ($signed({{(CW-RT_W){1'b0}}, sin_w})),
      .z_o   (acos_ang[l])
    );
  end

  // ---------------- align coxa and alpha with the cosine lanes ----------------
  logic signed [ZW-1:0] coxa_dly_q  [D_COXA];
  logic signed [ZW-1:0] alpha_dly_q [D_ALPHA];

  always_ff @(posedge clk_i) begin
    if (en) begin
      coxa_dly_q[0]  <= coxa_z;
      alpha_dly_q[0] <= alpha_z;
      for (int i = 1; i < D_COXA; i++)  coxa_dly_q[i]  <= coxa_dly_q[i-1];
      for (int i = 1; i < D_ALPHA; i++) alpha_dly_q[i] <= alpha_dly_q[i-1];
    end
  end

  // ---------------- servo angles ----------------
  logic signed [AW-1:0] coxa_sum, femur_sum, tibia_sum;
  logic [3*OW-1:0]      res;

  assign coxa_sum  = AW'(lik_pkg::DEG90) + AW'(coxa_dly_q[D_COXA-1]);
  assign femur_sum = AW'(lik_pkg::DEG90) + AW'(alpha_dly_q[D_ALPHA-1]) - AW'(acos_ang[1]);
  assign tibia_sum = AW'(lik_pkg::DEG180) - AW'(acos_ang[0]);
  assign res       = {to_out(tibia_sum), to_out(femur_sum), to_out(coxa_sum)};

  // ---------------- output register and skid ----------------
  logic [3*OW-1:0] out_q, skid_q;
  logic            push;

  assign push = en && vld_q[T_ANG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      // Drain the skid first; it blocks new items while full
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (push)    out_q <= res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(48 - 3 * OW)'(0), out_q};

endmodule
`default_nettype wire
